@@ design/bfbd_pkg.sv @@
`timescale 1ns / 1ps

package bfbd_pkg;

   localparam int WORD_BITS  = 64;
   localparam int COUNT_BITS = 9;

   // reset value of the occupancy limit register
   localparam logic [COUNT_BITS-1:0] MAX_ENTRIES_RESET = 9'd256;
   localparam logic [COUNT_BITS-1:0] MIN_LIMIT         = 9'd4;

   // operation codes on the request channel
   localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
   localparam logic [1:0] FUNC_DEQUEUE = 2'd1;
   localparam logic [1:0] FUNC_REMOVE  = 2'd2;

   // response status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef enum logic [1:0] {
      OP_ENQUEUE,
      OP_DEQUEUE,
      OP_REMOVE,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic [1:0]            func;
      logic [WORD_BITS-1:0]  in_word;
      logic [COUNT_BITS-1:0] drop_request;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]  out_word;
      logic                  status;
      logic [COUNT_BITS-1:0] discarded;
      logic [COUNT_BITS-1:0] occupancy;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      op_type                op;
      logic [WORD_BITS-1:0]  word;
      logic [COUNT_BITS-1:0] count;
   } work_type;

   // handshake between front queue and back
   typedef struct packed {
      logic     valid;
      work_type item;
   } work_chan_type;

endpackage

@@ design/bounded_fifo_bulk_drop.sv @@
`timescale 1ns / 1ps

// bounded fifo of payload words with bulk drop of the oldest entries. each
// request item is an enqueue, a dequeue or a remove of up to drop_request of
// the oldest entries; every item gives exactly one response item carrying the
// occupancy after it. an enqueue that finds the occupancy at or above the limit
// (csr_data, clamped to the range 4..DEPTH) first drops the oldest limit/4
// entries and reports that count in discarded. a dequeue on an empty fifo
// answers status 1 and a zero word; an unused operation code changes nothing.
// the front decodes requests into a two-entry queue, so it takes up to two
// items while the back works or the response waits. the back updates the ring
// pointers and starts the ring memory read, then moves the registered read data
// to the response register, and takes no new item till then. the user must
// write the limit register only while the block is idle; it is not enforced.

module bounded_fifo_bulk_drop
   import bfbd_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int WORD_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   // limit register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [COUNT_BITS-1:0] csr_data
);

   logic [COUNT_BITS-1:0] max_entries_ff, max_entries_in;
   work_chan_type         work_chan;
   logic                  work_ready;

   // limit register, always writable
   assign csr_ready      = 1'b1;
   assign max_entries_in = (csr_valid && csr_ready) ? csr_data : max_entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= MAX_ENTRIES_RESET;
      end else begin
         max_entries_ff <= max_entries_in;
      end
   end

   // decode and queue
   bfbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .work_out   (work_chan),
      .work_ready (work_ready)
   );

   // ring pointers, ring memory and response register
   bfbd_back #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .max_entries (max_entries_ff),
      .work_in     (work_chan),
      .work_ready  (work_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

@@ design/bfbd_ram.sv @@
`timescale 1ns / 1ps

module bfbd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bfbd_front.sv @@
`timescale 1ns / 1ps

module bfbd_front
   import bfbd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output work_chan_type work_out,
   input  logic          work_ready
);

   work_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   work_type   classified;
   logic       push;
   logic       pop;

   // decode the operation
   always_comb begin
      classified.word  = req_data.in_word;
      classified.count = req_data.drop_request;
      case (req_data.func)
         FUNC_ENQUEUE: classified.op = OP_ENQUEUE;
         FUNC_DEQUEUE: classified.op = OP_DEQUEUE;
         FUNC_REMOVE:  classified.op = OP_REMOVE;
         default:      classified.op = OP_NONE;
      endcase
   end

   assign req_ready      = (count_ff != 2'd2);
   assign push           = req_valid && req_ready;
   assign work_out.valid = (count_ff != 2'd0);
   assign work_out.item  = slot_ff[rd_ptr_ff];
   assign pop            = work_out.valid && work_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

@@ design/bfbd_back.sv @@
`timescale 1ns / 1ps

module bfbd_back
   import bfbd_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int WORD_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COUNT_BITS-1:0] max_entries,
   input  work_chan_type         work_in,
   output logic                  work_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int XW = (CW > COUNT_BITS) ? CW : COUNT_BITS;
   localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
   localparam logic [XW-1:0] MIN_X   = XW'(MIN_LIMIT);
   localparam logic [PW-1:0] LAST_IX = PW'(DEPTH - 1);

   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [CW-1:0] fill_ff, fill_in;

   logic                  pend_ff;
   logic                  pend_status_ff, pend_status_in;
   logic                  pend_deq_ff, pend_deq_in;
   logic [COUNT_BITS-1:0] pend_disc_ff, pend_disc_in;
   logic [COUNT_BITS-1:0] pend_occ_ff, pend_occ_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [XW-1:0] max_x, lim_x, fill_x, want_x;
   logic [CW-1:0] n_drop, fill_drop;
   logic [SW-1:0] sum_raw;
   logic [PW-1:0] head_drop;
   logic          exec;
   logic          wr_en, rd_en;
   logic [WORD_WIDTH-1:0] rd_word;

   assign exec       = work_in.valid && !pend_ff && (!rsp_valid_ff || rsp_ready);
   assign work_ready = exec;

   // bulk drop: limit clamp, quarter and ring advance
   always_comb begin
      max_x  = XW'(max_entries);
      fill_x = XW'(fill_ff);
      lim_x  = max_x;
      if (max_x < MIN_X) begin
         lim_x = MIN_X;
      end else if (max_x > DEPTH_X) begin
         lim_x = DEPTH_X;
      end
      case (work_in.item.op)
         OP_ENQUEUE: want_x = (fill_x >= lim_x) ? (lim_x >> 2) : '0;
         OP_REMOVE:  want_x = XW'(work_in.item.count);
         default:    want_x = '0;
      endcase
      n_drop    = (want_x < fill_x) ? CW'(want_x) : fill_ff;
      sum_raw   = SW'(head_ff) + SW'(n_drop);
      head_drop = (sum_raw >= SW'(DEPTH)) ? PW'(sum_raw - SW'(DEPTH)) : sum_raw[PW-1:0];
      fill_drop = fill_ff - n_drop;
   end

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      pend_status_in = STATUS_OK;
      pend_deq_in    = 1'b0;
      pend_disc_in   = '0;
      if (exec) begin
         case (work_in.item.op)
            OP_ENQUEUE: begin
               head_in      = head_drop;
               fill_in      = fill_drop;
               pend_disc_in = COUNT_BITS'(n_drop);
               if (fill_drop < CW'(DEPTH)) begin
                  wr_en   = 1'b1;
                  tail_in = (tail_ff == LAST_IX) ? '0 : tail_ff + 1'b1;
                  fill_in = fill_drop + 1'b1;
               end
            end
            OP_DEQUEUE: begin
               if (fill_ff == '0) begin
                  pend_status_in = STATUS_EMPTY;
               end else begin
                  rd_en       = 1'b1;
                  pend_deq_in = 1'b1;
                  head_in     = (head_ff == LAST_IX) ? '0 : head_ff + 1'b1;
                  fill_in     = fill_ff - 1'b1;
               end
            end
            OP_REMOVE: begin
               head_in      = head_drop;
               fill_in      = fill_drop;
               pend_disc_in = COUNT_BITS'(n_drop);
            end
            default: begin
            end
         endcase
      end
      pend_occ_in = COUNT_BITS'(fill_in);
   end

   bfbd_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (work_in.item.word[WORD_WIDTH-1:0]),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_word)
   );

   // result register, loaded once the ring read has landed
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (pend_ff) begin
         rsp_data_in.out_word = '0;
         if (pend_deq_ff) begin
            rsp_data_in.out_word[WORD_WIDTH-1:0] = rd_word;
         end
         rsp_data_in.status    = pend_status_ff;
         rsp_data_in.discarded = pend_disc_ff;
         rsp_data_in.occupancy = pend_occ_ff;
      end
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         pend_ff      <= exec;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         pend_status_ff <= pend_status_in;
         pend_deq_ff    <= pend_deq_in;
         pend_disc_ff   <= pend_disc_in;
         pend_occ_ff    <= pend_occ_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import bfbd_pkg::*;

   localparam int RING_DEPTH   = 256;
   localparam int HALF_PERIOD  = 6;
   localparam int TAIL_CYCLES  = 20;
   localparam int TIMEOUT_NS   = 4_000_000;
   localparam int REPORT_LIMIT = 10;
   // the one selector value that the package gives no name
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_BITS-1:0] csr_data  = '0;

   // shadow copy of the ring, its pointers and the limit register
   logic [WORD_BITS-1:0]  shadow_words [RING_DEPTH];
   int                    shadow_head  = 0;
   int                    shadow_tail  = 0;
   int                    shadow_fill  = 0;
   logic [COUNT_BITS-1:0] shadow_limit = MAX_ENTRIES_RESET;

   // expected response items, oldest first
   rsp_type pending_rsps [$];

   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int hold_off_cycles = 0;

   int items_sent      = 0;
   int results_checked = 0;
   int mismatch_count  = 0;
   int drop_results    = 0;
   int empty_results   = 0;
   int limit_writes    = 0;

   bounded_fifo_bulk_drop i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // discard up to want of the oldest shadow entries, return how many went
   function automatic int shadow_drop_oldest(int want);
      int n;
      n = (want < shadow_fill) ? want : shadow_fill;
      shadow_head = (shadow_head + n) % RING_DEPTH;
      shadow_fill = shadow_fill - n;
      return n;
   endfunction

   // apply one request item to the shadow fifo and work out its response item
   function automatic rsp_type predict_fifo_op(req_type item);
      rsp_type res;
      int      lim;
      res = '0;
      case (item.func)
         FUNC_ENQUEUE: begin
            // limit is clamped to 4..DEPTH so an overflow drop always frees room
            lim = int'(shadow_limit);
            if (lim < int'(MIN_LIMIT))
               lim = int'(MIN_LIMIT);
            if (lim > RING_DEPTH)
               lim = RING_DEPTH;
            if (shadow_fill >= lim)
               res.discarded = COUNT_BITS'(shadow_drop_oldest(lim / 4));
            if (shadow_fill < RING_DEPTH) begin
               shadow_words[shadow_tail] = item.in_word;
               shadow_tail = (shadow_tail + 1) % RING_DEPTH;
               shadow_fill = shadow_fill + 1;
            end
         end
         FUNC_DEQUEUE: begin
            if (shadow_fill == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.out_word = shadow_words[shadow_head];
               shadow_head = (shadow_head + 1) % RING_DEPTH;
               shadow_fill = shadow_fill - 1;
            end
         end
         FUNC_REMOVE: begin
            res.discarded = COUNT_BITS'(shadow_drop_oldest(int'(item.drop_request)));
         end
         default: begin
            // unused selector: nothing changes
         end
      endcase
      res.occupancy = COUNT_BITS'(shadow_fill);
      return res;
   endfunction

   function automatic req_type make_item(logic [1:0] func, logic [WORD_BITS-1:0] word,
                                         logic [COUNT_BITS-1:0] count);
      req_type item;
      item.func         = func;
      item.in_word      = word;
      item.drop_request = count;
      return item;
   endfunction

   // random item; enq_pct steers the mix towards filling or draining
   function automatic req_type make_random_item(int enq_pct);
      req_type item;
      int      pick;
      item.in_word      = {$urandom, $urandom};
      item.drop_request = COUNT_BITS'($urandom_range(511));
      if ($urandom_range(15) == 0)
         item.in_word = $urandom_range(1) ? '1 : '0;
      if ($urandom_range(99) < enq_pct) begin
         item.func = FUNC_ENQUEUE;
      end else begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            item.func = FUNC_DEQUEUE;
         end else if (pick < 95) begin
            item.func = FUNC_REMOVE;
            // mostly small removes, now and then a large one
            if ($urandom_range(9) != 0)
               item.drop_request = COUNT_BITS'($urandom_range(8));
         end else begin
            item.func = FUNC_UNUSED;
         end
      end
      return item;
   endfunction

   // offer one item, with random idle cycles in front, and hold it until taken
   task automatic send_item(req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      pending_rsps.push_back(predict_fifo_op(item));
      items_sent++;
   endtask

   // sender goes quiet until every response item is back, then idles for a tail
   task automatic wait_all_answered();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // limit register is only written with the block idle
   task automatic write_limit(logic [COUNT_BITS-1:0] value);
      wait_all_answered();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      shadow_limit = value;
      limit_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: a long hold-off when asked, otherwise random stalls
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_off_cycles = hold_off_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // every response item is compared field by field with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (pending_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected response item word %h status %0d disc %0d occ %0d",
                        $realtime, rsp_data.out_word, rsp_data.status,
                        rsp_data.discarded, rsp_data.occupancy);
         end else begin
            want = pending_rsps.pop_front();
            if (want.discarded != 0)
               drop_results++;
            if (want.status == STATUS_EMPTY)
               empty_results++;
            if (rsp_data.out_word !== want.out_word || rsp_data.status !== want.status ||
                rsp_data.discarded !== want.discarded ||
                rsp_data.occupancy !== want.occupancy) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: mismatch on response item %0d", $realtime, results_checked);
                  $display("   expected word %h status %0d disc %0d occ %0d",
                           want.out_word, want.status, want.discarded, want.occupancy);
                  $display("   actual   word %h status %0d disc %0d occ %0d",
                           rsp_data.out_word, rsp_data.status, rsp_data.discarded,
                           rsp_data.occupancy);
               end
            end
         end
      end
   end

   // empty fifo: dequeue answers empty, remove finds nothing, unused code is a no-op
   task automatic test_empty_fifo();
      send_item(make_item(FUNC_DEQUEUE, '1, '0));
      send_item(make_item(FUNC_REMOVE, '0, '1));
      send_item(make_item(FUNC_UNUSED, '1, '1));
   endtask

   // extreme and alternating words go in and come back out in order
   task automatic test_word_extremes();
      send_item(make_item(FUNC_ENQUEUE, '1, '1));
      send_item(make_item(FUNC_ENQUEUE, '0, '0));
      send_item(make_item(FUNC_ENQUEUE, {32{2'b10}}, 9'h155));
      send_item(make_item(FUNC_ENQUEUE, {32{2'b01}}, 9'h0aa));
      repeat (4) send_item(make_item(FUNC_DEQUEUE, {$urandom, $urandom}, '0));
   endtask

   // limit below the minimum, limit lowered under the occupancy, oversized remove
   task automatic test_limit_cases();
      int i;
      // zero is taken as four: the fifth enqueue drops one
      write_limit('0);
      for (i = 0; i < 5; i++)
         send_item(make_item(FUNC_ENQUEUE, {$urandom, $urandom}, '0));
      write_limit(9'd7);
      for (i = 0; i < 3; i++)
         send_item(make_item(FUNC_ENQUEUE, {$urandom, $urandom}, '0));
      // seven stored, limit now five: only one goes, occupancy stays above the limit
      write_limit(9'd5);
      send_item(make_item(FUNC_ENQUEUE, {$urandom, $urandom}, '0));
      // asks for more than is stored
      send_item(make_item(FUNC_REMOVE, '0, 9'd300));
   endtask

   // receiver holds off long enough for the block to fill and stall its input
   task automatic test_backpressure();
      int i;
      write_limit(MAX_ENTRIES_RESET);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      @(posedge clock);
      hold_off_cycles = 150;
      for (i = 0; i < 24; i++)
         send_item(make_random_item(60));
      // sender now waits for every outstanding response item
      wait_all_answered();
   endtask

   // random bursts, each leaning towards filling, draining, or neither
   task automatic test_random_phase(int send_pct, int stall_pct,
                                    logic [COUNT_BITS-1:0] limit, int n_items, int fill_pct);
      int sent;
      int burst;
      int enq_pct;
      int pick;
      write_limit(limit);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(8, 40);
         if ($urandom_range(99) < fill_pct) begin
            enq_pct = 95;
         end else begin
            pick = $urandom_range(2);
            enq_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : 70;
         end
         repeat (burst) begin
            send_item(make_random_item(enq_pct));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_fifo();
      test_word_extremes();
      test_limit_cases();
      test_backpressure();

      // above DEPTH clamps to DEPTH, long fill-heavy run reaches the full ring
      test_random_phase(0, 0, 9'd511, 400, 90);
      // below the minimum clamps to four
      test_random_phase(68, 0, 9'd3, 220, 50);
      test_random_phase(0, 68, 9'($urandom_range(5, 40)), 220, 50);
      test_random_phase(37, 37, 9'($urandom_range(33, 120)), 240, 70);

      wait_all_answered();
      $display("covered %0d request items, %0d response items checked, %0d limit writes",
               items_sent, results_checked, limit_writes);
      $display("responses with entries dropped: %0d, dequeues on an empty fifo: %0d",
               drop_results, empty_results);
      if (mismatch_count == 0 && pending_rsps.size() == 0)
         $display("bounded_fifo_bulk_drop regression: pass");
      else
         $display("bounded_fifo_bulk_drop regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #TIMEOUT_NS;
      $display("timeout with %0d response items outstanding", pending_rsps.size());
      $display("bounded_fifo_bulk_drop regression: fail");
      $finish;
   end

endmodule

@@ bounded_fifo_bulk_drop.f @@
design/bfbd_pkg.sv
design/bfbd_ram.sv
design/bfbd_front.sv
design/bfbd_back.sv
design/bounded_fifo_bulk_drop.sv
tb/tb_top.sv
